// File: rtl/text_field_line_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Text field line parser assertion macros
// Shared assertion forms for the line parser checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_FIELD_LINE_PARSER_UNIT_MACROS_SVH
`define TEXT_FIELD_LINE_PARSER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TFLP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define TFLP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tflp_pkg.sv
// ----------------------------------------------------------------------------
// Text field line parser package
// Types, character codes, key table and field identifiers.
// ----------------------------------------------------------------------------
package tflp_pkg;

  localparam int LINE_MAX_DEF = 64;

  localparam int KEY_COUNT = 13;
  localparam int KEY_MAX   = 8;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MIN_FIELDS   = 8'd0;
  localparam logic [7:0] CFG_FRESH_WINDOW = 8'd1;

  localparam logic [7:0]  MIN_FIELDS_RST   = 8'd3;
  localparam logic [15:0] FRESH_WINDOW_RST = 16'd5000;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;

  // Field identifiers.
  localparam logic [3:0] ID_SOC      = 4'd2;
  localparam logic [3:0] ID_ALARM    = 4'd5;
  localparam logic [3:0] ID_RELAY    = 4'd6;
  localparam logic [3:0] ID_CHECKSUM = 4'd12;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  // Keys packed with the first character in the highest used byte.
  localparam logic [63:0] KEY_TEXT [KEY_COUNT] = '{
    64'h56,                  // V
    64'h49,                  // I
    64'h53_4F_43,            // SOC
    64'h54_54_47,            // TTG
    64'h43_45,               // CE
    64'h41_6C_61_72_6D,      // Alarm
    64'h52_65_6C_61_79,      // Relay
    64'h48_31,               // H1
    64'h48_32,               // H2
    64'h48_34,               // H4
    64'h48_37,               // H7
    64'h48_38,               // H8
    64'h43_68_65_63_6B_73_75_6D  // Checksum
  };

  localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
    4'd1, 4'd1, 4'd3, 4'd3, 4'd2, 4'd5, 4'd5, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd8
  };

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } num_phase_e;

  typedef enum logic [1:0] {
    ON_EMPTY,
    ON_SEEN_O,
    ON_SEEN_ON,
    ON_OTHER
  } on_match_e;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
  } key_match_t;

  // Event of a completed line, passed from the line parser to the status logic.
  typedef struct packed {
    logic        hit;
    logic [3:0]  id;
    logic [31:0] value;
    logic        counted;
    logic        checksum;
  } line_event_t;

  typedef struct packed {
    logic        event_valid;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic        data_fresh;
  } result_t;

  function automatic key_match_t key_lookup(input logic [63:0] text, input logic [3:0] len);
    key_match_t m;
    m = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (len == KEY_LEN[k] && text == KEY_TEXT[k]) begin
        m.hit = 1'b1;
        m.id  = 4'(k);
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/tflp_line.sv
// ----------------------------------------------------------------------------
// Line parser
// Collects one text line, splits key from value and decodes the value.
// ----------------------------------------------------------------------------
module tflp_line import tflp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        cmd_i,
  input  logic [7:0]  byte_i,
  output line_event_t event_o
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [3:0] KEY_SAT = 4'(KEY_MAX + 1);

  logic [CW-1:0] char_count_q, char_count_d;
  logic [63:0]   key_text_q, key_text_d;
  logic [3:0]    key_length_q, key_length_d;
  logic          in_value_q, in_value_d;
  num_phase_e    phase_q, phase_d;
  logic          negative_q, negative_d;
  logic [31:0]   magnitude_q, magnitude_d;
  on_match_e     on_q, on_d;

  logic       is_digit;
  logic [3:0] digit;
  logic [35:0] mag_next;
  key_match_t  match;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = byte_i[3:0];
  // Ten times the magnitude plus the new digit, wide enough not to wrap.
  assign mag_next = {1'b0, magnitude_q, 3'b000} + {3'b000, magnitude_q, 1'b0}
                  + {32'd0, digit};
  assign match    = key_lookup(key_text_q, key_length_q);

  always_comb begin
    char_count_d = char_count_q;
    key_text_d   = key_text_q;
    key_length_d = key_length_q;
    in_value_d   = in_value_q;
    phase_d      = phase_q;
    negative_d   = negative_q;
    magnitude_d  = magnitude_q;
    on_d         = on_q;
    event_o      = '0;

    if (fire_i && !cmd_i) begin
      if (byte_i == CH_LF) begin
        if (char_count_q != '0 && in_value_q && match.hit) begin
          event_o.hit      = 1'b1;
          event_o.id       = match.id;
          event_o.counted  = (match.id <= ID_SOC);
          event_o.checksum = (match.id == ID_CHECKSUM);
          if (match.id == ID_ALARM || match.id == ID_RELAY) begin
            event_o.value = {31'd0, on_q == ON_SEEN_ON};
          end else if (match.id == ID_CHECKSUM) begin
            event_o.value = '0;
          end else if (negative_q) begin
            event_o.value = 32'd0 - magnitude_q;
          end else begin
            event_o.value = (magnitude_q > POS_LIMIT) ? POS_LIMIT : magnitude_q;
          end
        end
        char_count_d = '0;
        key_text_d   = '0;
        key_length_d = '0;
        in_value_d   = 1'b0;
        phase_d      = PH_SKIP;
        negative_d   = 1'b0;
        magnitude_d  = '0;
        on_d         = ON_EMPTY;
      end else if (byte_i != CH_CR && char_count_q < CW'(LINE_MAX)) begin
        char_count_d = char_count_q + CW'(1);
        if (!in_value_q) begin
          if (byte_i == CH_TAB) begin
            in_value_d = 1'b1;
          end else begin
            if (key_length_q < 4'(KEY_MAX)) begin
              key_text_d = {key_text_q[55:0], byte_i};
            end
            // Lengths past eight never match, so the count stops one above.
            if (key_length_q < KEY_SAT) begin
              key_length_d = key_length_q + 4'd1;
            end
          end
        end else begin
          case (phase_q)
            PH_SKIP: begin
              if (byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_VT ||
                  byte_i == CH_FF) begin
                phase_d = PH_SKIP;
              end else if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
                negative_d = (byte_i == CH_MINUS);
                phase_d    = PH_DIGITS;
              end else if (is_digit) begin
                magnitude_d = {28'd0, digit};
                phase_d     = PH_DIGITS;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                magnitude_d = (mag_next > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_next[31:0];
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: phase_d = phase_q;
          endcase

          if (on_q == ON_EMPTY && byte_i == CH_O) begin
            on_d = ON_SEEN_O;
          end else if (on_q == ON_SEEN_O && byte_i == CH_N) begin
            on_d = ON_SEEN_ON;
          end else begin
            on_d = ON_OTHER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      key_text_q   <= '0;
      key_length_q <= '0;
      in_value_q   <= 1'b0;
      phase_q      <= PH_SKIP;
      negative_q   <= 1'b0;
      magnitude_q  <= '0;
      on_q         <= ON_EMPTY;
    end else begin
      char_count_q <= char_count_d;
      key_text_q   <= key_text_d;
      key_length_q <= key_length_d;
      in_value_q   <= in_value_d;
      phase_q      <= phase_d;
      negative_q   <= negative_d;
      magnitude_q  <= magnitude_d;
      on_q         <= on_d;
    end
  end

endmodule

// File: rtl/tflp_status.sv
// ----------------------------------------------------------------------------
// Block status tracker
// Counts fields per block, sets the valid flag on a checksum line when enough fields were counted, and ages it.
// ----------------------------------------------------------------------------
module tflp_status import tflp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  line_event_t event_i,
  input  logic [7:0]  min_fields_i,
  input  logic [15:0] fresh_window_i,
  output logic        data_fresh_o
);

  logic [7:0]  field_count_q, field_count_d;
  logic        valid_q, valid_d;
  logic [15:0] age_q, age_d;

  always_comb begin
    field_count_d = field_count_q;
    valid_d       = valid_q;
    age_d         = age_q;
    if (tick_i) begin
      if (age_q != 16'hFFFF) begin
        age_d = age_q + 16'd1;
      end
    end else if (event_i.hit) begin
      if (event_i.checksum) begin
        if (field_count_q >= min_fields_i) begin
          valid_d = 1'b1;
          age_d   = '0;
        end
        field_count_d = '0;
      end else if (event_i.counted && field_count_q != 8'hFF) begin
        field_count_d = field_count_q + 8'd1;
      end
    end
    // Freshness reflects this transaction's own update.
    data_fresh_o = valid_d && (age_d < fresh_window_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q <= '0;
      valid_q       <= 1'b0;
      age_q         <= '0;
    end else begin
      field_count_q <= field_count_d;
      valid_q       <= valid_d;
      age_q         <= age_d;
    end
  end

endmodule

// File: rtl/text_field_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Text field line parser
// Key/value text line parser with block validity and freshness tracking.
// ----------------------------------------------------------------------------
// Each transaction carries one received character or one millisecond tick and
// produces exactly one result. The unit takes one transaction per clock cycle
// while its input is not stalled. An accepted transaction is first held in the
// input register, then the character update (key shift, decimal accumulate by
// ten, and the key table compare at the end of a line) is written into the
// result register when the transaction fires.
// A stalled result holds the pipeline; the input side stalls only while the
// input register is full and cannot move on. Configuration writes are always
// ready and should only be issued while no transaction is in flight.
module text_field_line_parser_unit import tflp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               event_valid_o,
  output logic [3:0]         field_id_o,
  output logic signed [31:0] field_value_o,
  output logic               data_fresh_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic        in_valid_q;
  logic        cmd_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  result_t     result_q, result_d;
  logic [7:0]  min_fields_q;
  logic [15:0] fresh_window_q;
  logic        advance;
  logic        fire;
  line_event_t line_event;
  logic        fresh;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_fields_q   <= MIN_FIELDS_RST;
      fresh_window_q <= FRESH_WINDOW_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MIN_FIELDS) begin
        min_fields_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == CFG_FRESH_WINDOW) begin
        fresh_window_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= cmd_i;
      byte_q <= rx_byte_i;
    end
  end

  tflp_line #(
    .LINE_MAX(LINE_MAX)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cmd_i  (cmd_q),
    .byte_i (byte_q),
    .event_o(line_event)
  );

  tflp_status u_status (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (fire && cmd_q),
    .event_i       (line_event),
    .min_fields_i  (min_fields_q),
    .fresh_window_i(fresh_window_q),
    .data_fresh_o  (fresh)
  );

  always_comb begin
    result_d.event_valid = line_event.hit;
    result_d.field_id    = line_event.id;
    result_d.field_value = line_event.value;
    result_d.data_fresh  = fresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = result_q.event_valid;
  assign field_id_o    = result_q.field_id;
  assign field_value_o = signed'(result_q.field_value);
  assign data_fresh_o  = result_q.data_fresh;

endmodule

// File: rtl/tflp_checker.sv
// ----------------------------------------------------------------------------
// Text field line parser checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`include "text_field_line_parser_unit_macros.svh"

module tflp_checker import tflp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               event_valid_o,
  input logic [3:0]         field_id_o,
  input logic signed [31:0] field_value_o
);

  `TFLP_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")
  `TFLP_ASSERT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `TFLP_ASSERT(a_quiet_no_event, clk_i, rst_ni, out_valid_o && !event_valid_o |-> field_id_o == 4'd0 && field_value_o == 32'sd0, "non-event result carries data")
  `TFLP_ASSERT(a_id_range, clk_i, rst_ni, out_valid_o && event_valid_o |-> field_id_o <= ID_CHECKSUM, "field id out of range")
  `TFLP_ASSERT(a_flag_value, clk_i, rst_ni, out_valid_o && event_valid_o && (field_id_o == ID_ALARM || field_id_o == ID_RELAY || field_id_o == ID_CHECKSUM) |-> field_value_o == 32'sd0 || (field_value_o == 32'sd1 && field_id_o != ID_CHECKSUM), "flag field value not 0 or 1")

endmodule

bind text_field_line_parser_unit tflp_checker u_checker (.*);

// File: tb/tflp_line_checker.sv
// ----------------------------------------------------------------------------
// Line parser result checker
// Watches the input, result and register channels of the line parser, keeps
// its own model of the parser state and compares every result in order.
// ----------------------------------------------------------------------------
module tflp_line_checker import tflp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               event_valid_i,
  input  logic [3:0]         field_id_i,
  input  logic signed [31:0] field_value_i,
  input  logic               data_fresh_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 events_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    FLD_V, FLD_I, FLD_SOC, FLD_TTG, FLD_CE, FLD_ALARM, FLD_RELAY,
    FLD_H1, FLD_H2, FLD_H4, FLD_H7, FLD_H8, FLD_CHECKSUM, FLD_NONE
  } field_e;

  string key_names [13] = '{"V", "I", "SOC", "TTG", "CE", "Alarm", "Relay",
                            "H1", "H2", "H4", "H7", "H8", "Checksum"};

  // Register copies.
  logic [7:0]  min_fields_cfg;
  logic [15:0] fresh_window_cfg;

  // Parser state.
  logic [6:0]  line_len;
  logic [63:0] key_shift;
  logic [6:0]  key_chars;
  logic        after_tab;
  num_phase_e  num_state;
  logic        neg_value;
  logic [31:0] magnitude;
  on_match_e   on_state;
  logic [7:0]  block_fields;
  logic        data_ok;
  logic [15:0] age;

  result_t parsed_q [$];
  result_t want_res;
  result_t got_res;
  int      failures;
  int      checked;
  int      events;

  task automatic start_new_line();
    line_len  = '0;
    key_shift = '0;
    key_chars = '0;
    after_tab = 1'b0;
    num_state = PH_SKIP;
    neg_value = 1'b0;
    magnitude = '0;
    on_state  = ON_EMPTY;
  endtask

  function automatic field_e match_key(input logic [63:0] txt, input logic [6:0] len);
    logic [63:0] packed_name;
    for (int k = 0; k < 13; k++) begin
      packed_name = '0;
      for (int i = 0; i < key_names[k].len(); i++) begin
        packed_name = {packed_name[55:0], key_names[k][i]};
      end
      if (int'(len) == key_names[k].len() && packed_name == txt) begin
        return field_e'(k);
      end
    end
    return FLD_NONE;
  endfunction

  task automatic take_value_char(input logic [7:0] ch);
    logic        digit;
    logic [63:0] wide;
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    case (num_state)
      PH_SKIP: begin
        if (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF) begin
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
          neg_value = (ch == CH_MINUS);
          num_state = PH_DIGITS;
        end else if (digit) begin
          magnitude = 32'(ch - CH_ZERO);
          num_state = PH_DIGITS;
        end else begin
          num_state = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          wide = 64'(magnitude) * 64'd10 + 64'(ch - CH_ZERO);
          magnitude = (wide > 64'(MAG_LIMIT)) ? MAG_LIMIT : wide[31:0];
        end else begin
          num_state = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (on_state == ON_EMPTY && ch == CH_O) begin
      on_state = ON_SEEN_O;
    end else if (on_state == ON_SEEN_O && ch == CH_N) begin
      on_state = ON_SEEN_ON;
    end else begin
      on_state = ON_OTHER;
    end
  endtask

  task automatic parse_input(input logic tick, input logic [7:0] ch, output result_t res);
    field_e fld;
    res = '0;
    if (tick) begin
      if (age != 16'hFFFF) age = age + 16'd1;
    end else if (ch == CH_LF) begin
      if (line_len != 0 && after_tab) begin
        fld = match_key(key_shift, key_chars);
        if (fld != FLD_NONE) begin
          res.event_valid = 1'b1;
          res.field_id    = fld;
          case (fld)
            FLD_ALARM, FLD_RELAY: begin
              res.field_value = {31'd0, on_state == ON_SEEN_ON};
            end
            FLD_CHECKSUM: begin
              if (block_fields >= min_fields_cfg) begin
                data_ok = 1'b1;
                age     = '0;
              end
              block_fields = '0;
            end
            default: begin
              if (neg_value) begin
                res.field_value = 32'd0 - magnitude;
              end else begin
                res.field_value = (magnitude > POS_LIMIT) ? POS_LIMIT : magnitude;
              end
              // Only V, I and SOC count toward a block.
              if (fld <= FLD_SOC && block_fields != 8'hFF) begin
                block_fields = block_fields + 8'd1;
              end
            end
          endcase
        end
      end
      start_new_line();
    end else if (ch == CH_CR) begin
    end else if (int'(line_len) < LINE_MAX) begin
      line_len = line_len + 7'd1;
      if (!after_tab) begin
        if (ch == CH_TAB) begin
          after_tab = 1'b1;
        end else begin
          if (key_chars < 7'd8) key_shift = {key_shift[55:0], ch};
          if (key_chars != 7'h7F) key_chars = key_chars + 7'd1;
        end
      end else begin
        take_value_char(ch);
      end
    end
    res.data_fresh = data_ok && (age < fresh_window_cfg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_fields_cfg   = MIN_FIELDS_RST;
      fresh_window_cfg = FRESH_WINDOW_RST;
      start_new_line();
      block_fields = '0;
      data_ok      = 1'b0;
      age          = '0;
      parsed_q.delete();
      failures     = 0;
      checked      = 0;
      events       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      events_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_res.event_valid = event_valid_i;
        got_res.field_id    = field_id_i;
        got_res.field_value = field_value_i;
        got_res.data_fresh  = data_fresh_i;
        checked++;
        if (event_valid_i) events++;
        if (parsed_q.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%t: result transaction with nothing pending", $time);
        end else begin
          want_res = parsed_q.pop_front();
          if (got_res.event_valid !== want_res.event_valid ||
              got_res.field_id !== want_res.field_id ||
              got_res.field_value !== want_res.field_value ||
              got_res.data_fresh !== want_res.data_fresh) begin
            failures++;
            if (failures <= 10) begin
              $display("%t: mismatch: expected ev=%0b id=%0d value=%0d fresh=%0b", $time,
                       want_res.event_valid, want_res.field_id,
                       $signed(want_res.field_value), want_res.data_fresh);
              $display("%t:           actual   ev=%0b id=%0d value=%0d fresh=%0b", $time,
                       got_res.event_valid, got_res.field_id,
                       $signed(got_res.field_value), got_res.data_fresh);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_FIELDS:   min_fields_cfg   = cfg_data_i[7:0];
          CFG_FRESH_WINDOW: fresh_window_cfg = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parse_input(cmd_i, rx_byte_i, want_res);
        parsed_q.push_back(want_res);
      end
      fail_count_o <= failures;
      pending_o    <= parsed_q.size();
      checked_o    <= checked;
      events_o     <= events;
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Line parser testbench
// Drives character and tick transactions and register writes into the line
// parser, with random idle bursts on both sides, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tflp_pkg::*;

  localparam logic [7:0] CFG_NO_SUCH_REG = 8'hA5;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               cmd_i;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               event_valid_o;
  logic [3:0]         field_id_o;
  logic signed [31:0] field_value_o;
  logic               data_fresh_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  int fail_count;
  int pending;
  int checked;
  int events;

  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_req     = 1'b0;
  int items_sent   = 0;
  int cfg_writes   = 0;

  logic [7:0] line_buf [$];

  string key_names [13] = '{"V", "I", "SOC", "TTG", "CE", "Alarm", "Relay",
                            "H1", "H2", "H4", "H7", "H8", "Checksum"};

  text_field_line_parser_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_valid_o (event_valid_o),
    .field_id_o    (field_id_o),
    .field_value_o (field_value_o),
    .data_fresh_o  (data_fresh_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tflp_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_valid_i (event_valid_o),
    .field_id_i    (field_id_o),
    .field_value_i (field_value_o),
    .data_fresh_i  (data_fresh_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .events_o      (events)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_item(input logic tick, input logic [7:0] ch);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= tick;
    rx_byte_i  <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic put(input logic [7:0] ch);
    line_buf.push_back(ch);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) send_item(1'b0, line_buf[i]);
    line_buf.delete();
  endtask

  task automatic send_line(input string key, input string val);
    put_str(key);
    put(CH_TAB);
    put_str(val);
    put(CH_LF);
    flush_line();
  endtask

  // Registers are written only while nothing is in flight.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_number();
    int n_ws;
    int r;
    n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n_ws; i++) begin
      case ($urandom_range(0, 3))
        0:       put(CH_SPACE);
        1:       put(CH_TAB);
        2:       put(CH_VT);
        default: put(CH_FF);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       put(CH_PLUS);
      1:       put(CH_MINUS);
      default: begin
      end
    endcase
    r = $urandom_range(0, 9);
    if (r < 6) begin
      put_digits($urandom_range(1, 4));
    end else if (r < 8) begin
      put_digits($urandom_range(5, 10));
    end else if (r == 8) begin
      put_digits($urandom_range(11, 16));
    end
    if ($urandom_range(0, 4) == 0) begin
      put(8'($urandom_range(33, 126)));
      put_digits($urandom_range(0, 3));
    end
  endtask

  task automatic send_known_line(input string key);
    put_str(key);
    put(CH_TAB);
    if ((key == "Alarm" || key == "Relay") && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0, 1:    put_str("ON");
        2:       put_str("OFF");
        3:       put_str("O");
        4:       put_str("ONN");
        default: put_str("N");
      endcase
    end else begin
      put_number();
    end
    if ($urandom_range(0, 9) == 0) put(CH_CR);
    put(CH_LF);
    flush_line();
  endtask

  task automatic send_broken_line();
    int n;
    case ($urandom_range(0, 4))
      0: begin
        // Missing tab.
        put_str(key_names[$urandom_range(0, ID_CHECKSUM)]);
        put(CH_SPACE);
        put_digits(2);
      end
      1: begin
        // Lower-case keys never match the table.
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) put(8'($urandom_range(97, 122)));
        put(CH_TAB);
        put_number();
      end
      2: begin
        put_str("Checksum");
        put(8'($urandom_range(33, 126)));
        put(CH_TAB);
        put_digits(1);
      end
      3: begin
        put_str(key_names[$urandom_range(0, ID_CHECKSUM)]);
        put(CH_TAB);
        n = $urandom_range(60, 90);
        for (int i = 0; i < n; i++) put(8'($urandom_range(32, 126)));
      end
      default: begin
        put(CH_TAB);
        put_number();
      end
    endcase
    put(CH_LF);
    flush_line();
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
    put(CH_LF);
    flush_line();
  endtask

  // One block: a few lines, mostly well formed, usually closed by a checksum.
  task automatic send_frame();
    int n;
    int r;
    n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_ticks($urandom_range(1, 5));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_known_line(key_names[$urandom_range(0, ID_SOC)]);
      end else if (r < 80) begin
        send_known_line(key_names[$urandom_range(ID_SOC + 1, ID_CHECKSUM - 1)]);
      end else if (r < 88) begin
        send_broken_line();
      end else if (r < 93) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 1) == 1) put(CH_CR);
        put(CH_LF);
        flush_line();
      end
    end
    if ($urandom_range(0, 6) != 0) send_known_line(key_names[ID_CHECKSUM]);
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) send_frame();
  endtask

  initial begin : result_sink
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Long hold-off so the parser fills up and stalls its input.
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    in_valid_i  <= 1'b0;
    cmd_i       <= 1'b0;
    rx_byte_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset register values.
    send_line("Checksum", "");
    send_line("V", "12800");
    send_line("I", "-3500");
    send_line("SOC", "+999");
    send_ticks(2);
    send_line("Checksum", "7");
    send_line("TTG", "2147483647");
    send_line("CE", "-2147483648");
    send_line("H1", "99999999999");
    send_line("H2", "-99999999999");
    send_line("Alarm", "ON");
    send_line("Relay", "OFF");
    send_line("Alarm", "ONX");
    send_line("Relay", "O");
    put_str("H4");
    put(CH_TAB);
    put(CH_SPACE);
    put(CH_TAB);
    put(CH_VT);
    put(CH_FF);
    put_str("42abc");
    put(CH_LF);
    flush_line();
    send_line("H7", "-");
    send_line("H8", "abc");
    put_str("V 5");
    put(CH_LF);
    put(CH_LF);
    put(CH_CR);
    put(CH_LF);
    flush_line();
    send_line("Voltage", "5");
    send_line("Checksum1", "0");
    put_str("V");
    put(CH_TAB);
    put_str("1");
    put(CH_CR);
    put_str("2");
    put(CH_LF);
    flush_line();
    // Characters past the line limit are dropped, so this one reads as 1.
    put_str("H1");
    put(CH_TAB);
    for (int i = 0; i < 60; i++) put(CH_SPACE);
    put_str("12345");
    put(CH_LF);
    // A tab that falls past the line limit is never seen.
    put_str("V");
    for (int i = 0; i < 70; i++) put(8'($urandom_range(97, 122)));
    put(CH_TAB);
    put_str("5");
    put(CH_LF);
    flush_line();
    send_ticks(3);

    // Narrowest window: fresh only until the next tick.
    drain();
    write_reg(CFG_MIN_FIELDS, 16'hAB00);
    write_reg(CFG_FRESH_WINDOW, 16'd1);
    write_reg(CFG_NO_SUCH_REG, 16'hFFFF);
    send_line("Checksum", "1");
    send_ticks(2);
    send_line("Checksum", "2");
    send_ticks(1);

    drain();
    write_reg(CFG_MIN_FIELDS, {8'($urandom_range(0, 255)), 8'($urandom_range(1, 5))});
    write_reg(CFG_FRESH_WINDOW, 16'($urandom_range(2, 60)));
    run_random(100);
    hold_req = 1'b1;
    run_random(150);

    // Widest settings: a short block stays below the field minimum.
    drain();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(CFG_MIN_FIELDS, 16'h00FF);
    write_reg(CFG_FRESH_WINDOW, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_line("V", "1");
    send_line("Checksum", "0");
    send_ticks(20);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    drain();
    write_reg(CFG_MIN_FIELDS, 16'd2);
    write_reg(CFG_FRESH_WINDOW, 16'($urandom_range(100, 400)));
    run_random(200);

    // Last part runs at full rate on both sides.
    drain();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(CFG_MIN_FIELDS, 16'(MIN_FIELDS_RST));
    write_reg(CFG_FRESH_WINDOW, FRESH_WINDOW_RST);
    run_random(200);

    drain();
    $display("summary: %0d transactions sent, %0d results checked, %0d line events",
             items_sent, checked, events);
    $display("summary: %0d register writes, including an unused index", cfg_writes);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tflp_pkg.sv
rtl/tflp_line.sv
rtl/tflp_status.sv
rtl/text_field_line_parser_unit.sv
rtl/tflp_checker.sv
tb/tflp_line_checker.sv
tb/testbench.sv
